>>> hdl/cgm_pkg.sv
// Shared constants, types and tap functions of the color gradient magnitude block.
package cgm_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int LS_DEPTH  = 4 * MAX_WIDTH + 8;
  localparam int AW        = $clog2(LS_DEPTH);
  localparam int WW        = 11;
  localparam int HW        = 16;
  localparam int CW        = 27;
  localparam int PIX_W     = 24;
  localparam int CFG_DW    = 16;
  localparam int CFG_IW    = 1;
  localparam int GX_W      = 17;
  localparam int RAD_W     = 40;
  localparam int RT_W      = RAD_W / 2;
  localparam int REM_W     = RT_W + 2;
  localparam int SUM_W     = 22;
  localparam int GRAD_W    = 15;
  localparam int DIVISOR   = 60;
  localparam int ROUNDING  = 30;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  // Divide by 60 as a drop of two bits, then a multiply by the rounded-up reciprocal of 15.
  // Exact for every sum below 2^22.
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = 21;
  localparam int PROD_W    = SUM_W - 2 + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + DIVISOR / 4 - 1) / (DIVISOR / 4));

  localparam logic [CFG_IW-1:0] REG_WIDTH  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_HEIGHT = CFG_IW'(1);

  localparam logic [WW-1:0] WIDTH_RST  = WW'(640);
  localparam logic [HW-1:0] HEIGHT_RST = HW'(480);
  localparam logic [CW-1:0] COUNT_RST  = CW'(640 * 480);

  typedef struct packed {
    logic             pixel;
    logic [AW-1:0]    waddr;
    logic [PIX_W-1:0] rgb;
    logic             emit;
    logic [AW-1:0]    base;
    logic             row_in;
    logic             col_in;
    logic             last;
  } task_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_SQ,
    BK_SQRT,
    BK_DIV,
    BK_OUT
  } back_state_e;

  function automatic int diff_tap(logic [2:0] idx);
    int t;
    t = 0;
    unique case (idx)
      3'd0:    t = -1;
      3'd1:    t = -2;
      3'd2:    t = 0;
      3'd3:    t = 2;
      3'd4:    t = 1;
      default: t = 0;
    endcase
    return t;
  endfunction

  function automatic int smooth_tap(logic [2:0] idx);
    int t;
    t = 0;
    unique case (idx)
      3'd0:    t = 1;
      3'd1:    t = 4;
      3'd2:    t = 6;
      3'd3:    t = 4;
      3'd4:    t = 1;
      default: t = 0;
    endcase
    return t;
  endfunction

  // Weight of one window position: derivative along d_idx, smoothing along s_idx.
  function automatic logic signed [4:0] grad_weight(logic diff_ok, logic smooth_ok,
                                                    logic [2:0] d_idx, logic [2:0] s_idx);
    int w;
    w = 0;
    if (diff_ok) begin
      if (smooth_ok) begin
        w = diff_tap(d_idx) * smooth_tap(s_idx);
      end else if (s_idx == 3'd2) begin
        w = 6 * diff_tap(d_idx);
      end
    end
    return 5'(w);
  endfunction

endpackage

>>> hdl/cgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cgm_ram #(
  parameter int Width = 24,
  parameter int Depth = 4104
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/cgm_fifo.sv
// Short task queue between the front and the back.
module cgm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cgm_pkg::task_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cgm_pkg::task_t data_o
);
  import cgm_pkg::*;

  task_t          mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QAW'(1);
      if (pop_i)  rp_q <= rp_q + QAW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

endmodule

>>> hdl/cgm_front.sv
// Front: configuration, frame position counters and result scheduling per beat.
module cgm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cgm_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [cgm_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [cgm_pkg::PIX_W-1:0]  s_tdata_i,
  input  logic                       s_tuser_i,
  input  logic                       full_i,
  output logic                       push_o,
  output cgm_pkg::task_t             task_o,
  output logic [cgm_pkg::WW-1:0]     img_w_o
);
  import cgm_pkg::*;

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] n_q;
  logic          hold_q;
  logic [CW-1:0] in_idx_q, out_count_q;
  logic [HW-1:0] out_row_q;
  logic [WW-1:0] out_col_q;
  logic [AW-1:0] wr_q;

  logic          acc, is_pix, emit;
  logic [CW-1:0] idx_inc, nxt_idx, idx, pend;
  logic [WW+1:0] two_w3;
  logic [AW-1:0] wr_inc, wa, pl, base;
  logic          row_in, col_in;

  always_comb begin
    if (width_q < WW'(5)) begin
      eff_w = WW'(5);
    end else if (width_q > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < HW'(5)) ? HW'(5) : height_q;
  end

  assign img_w_o    = eff_w;
  assign s_tready_o = !full_i && !hold_q;
  assign acc        = s_tvalid_i && s_tready_o;
  assign is_pix     = !s_tuser_i;

  always_comb begin
    idx_inc = in_idx_q + CW'(1);
    nxt_idx = (idx_inc == n_q) ? '0 : idx_inc;
    idx     = is_pix ? nxt_idx : in_idx_q;
    pend    = (idx >= out_count_q) ? idx - out_count_q : n_q - out_count_q + idx;
    two_w3  = {1'b0, eff_w, 1'b0} + (WW+2)'(3);
    emit    = is_pix ? (pend >= CW'(two_w3)) : (in_idx_q < out_count_q);
    wr_inc  = (wr_q == AW'(LS_DEPTH - 1)) ? '0 : wr_q + AW'(1);
    wa      = is_pix ? wr_inc : wr_q;
    pl      = pend[AW-1:0];
    base    = (wa >= pl) ? wa - pl : AW'((AW+1)'(LS_DEPTH) + {1'b0, wa} - {1'b0, pl});
    row_in  = (out_row_q >= HW'(2)) && ({1'b0, out_row_q} + (HW+1)'(2) < {1'b0, eff_h});
    col_in  = (out_col_q >= WW'(2)) && ({1'b0, out_col_q} + (WW+1)'(2) < {1'b0, eff_w});
  end

  assign push_o = acc && (is_pix || emit);

  always_comb begin
    task_o.pixel  = is_pix;
    task_o.waddr  = wr_q;
    task_o.rgb    = s_tdata_i;
    task_o.emit   = emit;
    task_o.base   = base;
    task_o.row_in = row_in;
    task_o.col_in = col_in;
    task_o.last   = (out_count_q == n_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      n_q         <= COUNT_RST;
      hold_q      <= 1'b0;
      in_idx_q    <= '0;
      out_count_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      wr_q        <= '0;
    end else begin
      n_q    <= CW'(eff_w) * CW'(eff_h);
      hold_q <= cfg_we_i;
      if (cfg_we_i) begin
        // Restart the frame on any register write.
        unique case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_wdata_i[WW-1:0];
          REG_HEIGHT: height_q <= cfg_wdata_i[HW-1:0];
          default:    width_q  <= width_q;
        endcase
        in_idx_q    <= '0;
        out_count_q <= '0;
        out_row_q   <= '0;
        out_col_q   <= '0;
      end else if (acc) begin
        if (is_pix) begin
          in_idx_q <= nxt_idx;
          wr_q     <= wr_inc;
        end
        if (emit) begin
          out_count_q <= (out_count_q + CW'(1) == n_q) ? '0 : out_count_q + CW'(1);
          if (out_col_q + WW'(1) == eff_w) begin
            out_col_q <= '0;
            out_row_q <= (out_row_q + HW'(1) == eff_h) ? '0 : out_row_q + HW'(1);
          end else begin
            out_col_q <= out_col_q + WW'(1);
          end
        end
      end
    end
  end

endmodule

>>> hdl/cgm_back.sv
// Back: line store, 5x5 window accumulation, square root and channel averaging.
module cgm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  cgm_pkg::task_t                task_i,
  input  logic [cgm_pkg::WW-1:0]        img_w_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [cgm_pkg::GRAD_W:0]      m_tdata_o,
  output logic                          m_tlast_o
);
  import cgm_pkg::*;

  back_state_e state_q, state_d;

  logic [PIX_W-1:0] rdata;
  logic [AW-1:0]    addr_q;
  logic [2:0]       dy_q, dx_q;
  logic             issuing_q, vld_q;
  logic signed [4:0] wx_q, wy_q;
  logic             row_in_q, col_in_q, last_q;
  logic signed [GX_W-1:0] gx_q [3];
  logic signed [GX_W-1:0] gy_q [3];
  logic [RAD_W-1:0] rad_q  [3];
  logic [REM_W-1:0] rem_q  [3];
  logic [RT_W-1:0]  root_q [3];
  logic [4:0]       it_q;
  logic [SUM_W-1:0] num_q, quot_q;
  logic [PROD_W-1:0] div_prod;

  logic [AW:0]      start_sum, step_sum;
  logic [AW-1:0]    step_inc;
  logic             acc_done, sqrt_done, div_done, out_free;

  cgm_ram #(.Width(PIX_W), .Depth(LS_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && task_i.pixel),
    .waddr_i (task_i.waddr),
    .wdata_i (task_i.rgb),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign pop_o     = (state_q == BK_IDLE) && !empty_i;
  assign acc_done  = !issuing_q && vld_q;
  assign sqrt_done = (it_q == 5'(RT_W - 1));
  assign div_done  = (it_q == 5'd1);
  assign out_free  = !m_tvalid_o || m_tready_i;

  always_comb begin
    // Window starts two rows and two columns before the center pixel.
    start_sum = {1'b0, task_i.base} + (AW+1)'(LS_DEPTH)
              - {1'b0, img_w_i, 1'b0} - (AW+1)'(2);
    if (start_sum >= (AW+1)'(LS_DEPTH)) start_sum = start_sum - (AW+1)'(LS_DEPTH);
    step_inc = (dx_q == 3'd4) ? AW'(img_w_i) - AW'(4) : AW'(1);
    step_sum = {1'b0, addr_q} + {1'b0, step_inc};
    if (step_sum >= (AW+1)'(LS_DEPTH)) step_sum = step_sum - (AW+1)'(LS_DEPTH);
    div_prod = PROD_W'(num_q[SUM_W-1:2]) * PROD_W'(DIV_RECIP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_o && task_i.emit) state_d = BK_ACC;
      BK_ACC:  if (acc_done) state_d = BK_SQ;
      BK_SQ:   state_d = BK_SQRT;
      BK_SQRT: if (sqrt_done) state_d = BK_DIV;
      BK_DIV:  if (div_done) state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      m_tvalid_o <= 1'b0;
      issuing_q  <= 1'b0;
      vld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_OUT && out_free) begin
        m_tvalid_o <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
      if (state_q == BK_IDLE) begin
        issuing_q <= pop_o && task_i.emit;
        vld_q     <= 1'b0;
      end else if (state_q == BK_ACC) begin
        vld_q <= issuing_q;
        if (issuing_q && dx_q == 3'd4 && dy_q == 3'd4) issuing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2*REM_W-REM_W+1:0] rn;
    logic [REM_W+1:0]         tr;
    logic signed [33:0]       sx, sy;
    logic [31:0]              sq;
    unique case (state_q)
      BK_IDLE: begin
        addr_q   <= start_sum[AW-1:0];
        dy_q     <= '0;
        dx_q     <= '0;
        row_in_q <= task_i.row_in;
        col_in_q <= task_i.col_in;
        last_q   <= task_i.last;
        for (int c = 0; c < 3; c++) begin
          gx_q[c] <= '0;
          gy_q[c] <= '0;
        end
      end
      BK_ACC: begin
        if (issuing_q) begin
          wx_q   <= grad_weight(col_in_q, row_in_q, dx_q, dy_q);
          wy_q   <= grad_weight(row_in_q, col_in_q, dy_q, dx_q);
          addr_q <= step_sum[AW-1:0];
          if (dx_q == 3'd4) begin
            dx_q <= '0;
            dy_q <= dy_q + 3'd1;
          end else begin
            dx_q <= dx_q + 3'd1;
          end
        end
        if (vld_q) begin
          // Skip zero weights so pixels outside the frame never enter the sum.
          for (int c = 0; c < 3; c++) begin
            if (wx_q != '0) begin
              gx_q[c] <= gx_q[c]
                       + GX_W'(wx_q) * GX_W'($signed({1'b0, rdata[8*c +: 8]}));
            end
            if (wy_q != '0) begin
              gy_q[c] <= gy_q[c]
                       + GX_W'(wy_q) * GX_W'($signed({1'b0, rdata[8*c +: 8]}));
            end
          end
        end
      end
      BK_SQ: begin
        for (int c = 0; c < 3; c++) begin
          sx = gx_q[c] * gx_q[c];
          sy = gy_q[c] * gy_q[c];
          sq = sx[31:0] + sy[31:0];
          rad_q[c]  <= {sq, 8'd0};
          rem_q[c]  <= '0;
          root_q[c] <= '0;
        end
        it_q <= '0;
      end
      BK_SQRT: begin
        for (int c = 0; c < 3; c++) begin
          rn = {rem_q[c], rad_q[c][RAD_W-1 -: 2]};
          tr = {2'b00, root_q[c], 2'b01};
          if (rn >= tr) begin
            rem_q[c]  <= REM_W'(rn - tr);
            root_q[c] <= {root_q[c][RT_W-2:0], 1'b1};
          end else begin
            rem_q[c]  <= REM_W'(rn);
            root_q[c] <= {root_q[c][RT_W-2:0], 1'b0};
          end
          rad_q[c] <= {rad_q[c][RAD_W-3:0], 2'b00};
        end
        if (sqrt_done) begin
          it_q <= '0;
        end else begin
          it_q <= it_q + 5'd1;
        end
      end
      BK_DIV: begin
        it_q <= it_q + 5'd1;
      end
      BK_OUT: begin
        if (out_free) begin
          m_tdata_o <= {1'b0, (quot_q > SUM_W'(32767)) ? GRAD_W'(32767) : quot_q[GRAD_W-1:0]};
          m_tlast_o <= last_q;
        end
      end
      default: it_q <= '0;
    endcase
  end

  // Divide the rounded channel sum by a constant: add up first, then multiply and shift.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_DIV) begin
      if (it_q == '0) begin
        num_q <= SUM_W'({2'b00, root_q[0]}) + SUM_W'({2'b00, root_q[1]})
               + SUM_W'({2'b00, root_q[2]}) + SUM_W'(ROUNDING);
      end else begin
        quot_q <= SUM_W'(div_prod[PROD_W-1:DIV_SHIFT]);
      end
    end
  end

endmodule

>>> hdl/color_gradient_magnitude.sv
// Top level of the streaming color gradient magnitude block.
// Order: a pixel's result follows 2*W+2 later pixels (or flush beats); once due, the
//   back works on it in turn: a dequeue, line store reads for the 5x5 window, a squaring,
//   20 square-root steps, 2 divide steps and an output load.
// Flow: the back takes the next beat only once the last result is loaded into the output,
//   and the output holds while the receiver stalls.
// Reset: frame counters clear, width 640 and height 480; the line store is not cleared.
module color_gradient_magnitude (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Register write port: index 0 image_width, index 1 image_height.
  input  logic                       cfg_we_i,
  input  logic [cgm_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [cgm_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [23:0]                s_axis_tdata_i,  // red[7:0], green[15:8], blue[23:16]
  input  logic                       s_axis_tuser_i,  // mode: 0 pixel, 1 flush
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,  // gradient[14:0], zero pad[15]
  output logic                       m_axis_tlast_o   // last_of_frame
);
  import cgm_pkg::*;

  task_t         front_task, back_task;
  logic          push, pop, full, empty;
  logic [WW-1:0] img_w;

  // Front: hold the registers, advance the frame counters, decide when a result is due.
  cgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .full_i      (full),
    .push_o      (push),
    .task_o      (front_task),
    .img_w_o     (img_w)
  );

  // Queue: decouple the front, which decides per beat, from the multi-cycle back.
  cgm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_task),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (back_task)
  );

  // Back: write the pixel into the line store, then compute the due result.
  cgm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .task_i     (back_task),
    .img_w_i    (img_w),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
